// ===== sv/cbm_pkg.sv =====
// Shared types and constants for the cartridge bank mapper.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package cbm_pkg;

  // Controller kind held in the configuration register
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_MBC1 = 2'd1,
    KIND_MBC3 = 2'd2,
    KIND_MBC5 = 2'd3
  } ctrl_kind_t;

  // Kind of external access a bus cycle turns into
  typedef enum logic [1:0] {
    ACC_NONE      = 2'd0,
    ACC_ROM_READ  = 2'd1,
    ACC_RAM_READ  = 2'd2,
    ACC_RAM_WRITE = 2'd3
  } access_kind_t;

  localparam int RomBankBytes   = 16384;
  localparam int RamBankBytes   = 8192;
  localparam int PhysWidth      = 23;
  localparam int RomBankWidth   = 9;
  localparam int RamBankWidth   = 4;

  localparam logic [15:0] RamWindowBase = 16'hA000;
  localparam logic [7:0]  RamEnableCode = 8'h0A;
  localparam logic [7:0]  RamDisableCode = 8'h00;
  localparam logic [3:0]  RamEnableNibble = 4'hA;
  localparam logic [7:0]  Mbc3MaxRamBank = 8'h07;
  localparam logic [7:0]  Mbc5MaxRamBank = 8'h0F;

  // Control range selected by address bits 14:13 (below 0x8000)
  localparam logic [1:0] RangeRamEnable = 2'd0;
  localparam logic [1:0] RangeRomBank   = 2'd1;
  localparam logic [1:0] RangeRamBank   = 2'd2;
  localparam logic [1:0] RangeMode      = 2'd3;

  // One CPU bus access
  typedef struct packed {
    logic        command;  // 1: write
    logic [15:0] address;
    logic [7:0]  value;
  } access_t;

  // Banking registers
  typedef struct packed {
    logic [RomBankWidth-1:0] rom_page;
    logic [RamBankWidth-1:0] ram_page;
    logic                    ram_on;
    logic                    bank_mode;
  } bank_state_t;

  // One translated access
  typedef struct packed {
    access_kind_t         kind;
    logic [PhysWidth-1:0] phys_address;
    logic [7:0]           write_data;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/cartridge_bank_mapper.sv =====
// Cartridge bank mapper: input register, translation, result register.
// One access per cycle while the result register is not stalled.
// The input register holds one access while the result register stalls.
// Banking registers update as the access moves to the result register.
// Synchronous reset: banks to ROM bank 1, RAM bank 0, RAM off, kind none.
`default_nettype none

module cartridge_bank_mapper #(
  parameter int RamBankBytes = cbm_pkg::RamBankBytes,
  parameter int RomBankBytes = cbm_pkg::RomBankBytes
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_wdata,     // controller_kind
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // [15:0] address, [23:16] value
  input  wire logic        s_axis_tuser,  // command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // [22:0] phys_address, [30:23] write_data, pad
  output logic [1:0]       m_axis_tuser   // access_kind
);

  logic                 in_valid;
  cbm_pkg::access_t     in_acc;
  logic                 out_valid;
  cbm_pkg::result_t     out_res;
  logic                 advance;
  cbm_pkg::ctrl_kind_t  kind;
  cbm_pkg::bank_state_t state;
  cbm_pkg::result_t     res;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  cbm_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .upd_en    (advance),
    .acc       (in_acc),
    .kind      (kind),
    .state     (state)
  );

  cbm_xlate #(
    .RamBankBytes (RamBankBytes),
    .RomBankBytes (RomBankBytes)
  ) u_xlate (
    .acc   (in_acc),
    .kind  (kind),
    .state (state),
    .res   (res)
  );

  // Input register: take a transfer when free or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_acc.command <= s_axis_tuser;
      in_acc.address <= s_axis_tdata[15:0];
      in_acc.value   <= s_axis_tdata[23:16];
    end
  end

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.kind;
  assign m_axis_tdata  = {1'b0, out_res.write_data, out_res.phys_address};

  // Idle result fields are zero
  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == cbm_pkg::ACC_NONE) |-> (m_axis_tdata == 32'd0))
    else $error("open-bus result carries nonzero address or data");

  // Write data only on a RAM write
  a_wdata_only_ram_write: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != cbm_pkg::ACC_RAM_WRITE) |-> (m_axis_tdata[30:23] == 8'd0))
    else $error("write data present on a non-write result");

  // Full pipeline with stalled output takes no new transfer
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_valid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while both stages are full and stalled");

  // A result waiting and not taken stays valid
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready) |=> out_valid)
    else $error("result lost while stalled");

  // Reset empties the result register
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

// ===== sv/cbm_regs.sv =====
// Banking registers and controller-kind register of the bank mapper.
// Depends on cbm_pkg; updated on control-range writes as an access retires.
`default_nettype none

module cbm_regs (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_wdata,
  input  wire logic               upd_en,
  input  wire cbm_pkg::access_t   acc,
  output cbm_pkg::ctrl_kind_t     kind,
  output cbm_pkg::bank_state_t    state
);

  cbm_pkg::bank_state_t state_next;
  logic [4:0]           mbc1_low;
  logic [6:0]           mbc3_bank;
  logic                 ctrl_write;

  assign ctrl_write = upd_en && acc.command && !acc.address[15];

  // Replace a zero bank select with bank one
  assign mbc1_low  = (acc.value[4:0] == 5'd0) ? 5'd1 : acc.value[4:0];
  assign mbc3_bank = (acc.value[6:0] == 7'd0) ? 7'd1 : acc.value[6:0];

  // Decode control writes by controller kind
  always_comb begin
    state_next = state;
    if (ctrl_write) begin
      unique case (kind)
        cbm_pkg::KIND_NONE: begin
          state_next = state;
        end
        cbm_pkg::KIND_MBC1: begin
          unique case (acc.address[14:13])
            cbm_pkg::RangeRamEnable:
              state_next.ram_on = (acc.value[3:0] == cbm_pkg::RamEnableNibble);
            cbm_pkg::RangeRomBank:
              state_next.rom_page = {2'b00, state.rom_page[6:5], mbc1_low};
            cbm_pkg::RangeRamBank: begin
              if (state.bank_mode) begin
                state_next.ram_page = {2'b00, acc.value[1:0]};
              end else begin
                state_next.rom_page = {2'b00, acc.value[1:0], state.rom_page[4:0]};
              end
            end
            default:
              state_next.bank_mode = acc.value[0];
          endcase
        end
        cbm_pkg::KIND_MBC3: begin
          unique case (acc.address[14:13])
            cbm_pkg::RangeRamEnable: begin
              if (acc.value == cbm_pkg::RamEnableCode) begin
                state_next.ram_on = 1'b1;
              end else if (acc.value == cbm_pkg::RamDisableCode) begin
                state_next.ram_on = 1'b0;
              end
            end
            cbm_pkg::RangeRomBank:
              state_next.rom_page = {2'b00, mbc3_bank};
            cbm_pkg::RangeRamBank: begin
              if (acc.value <= cbm_pkg::Mbc3MaxRamBank) begin
                state_next.ram_page = {1'b0, acc.value[2:0]};
              end
            end
            default:
              state_next.bank_mode = acc.value[0];
          endcase
        end
        default: begin
          // MBC5
          unique case (acc.address[14:13])
            cbm_pkg::RangeRamEnable: begin
              if (acc.value == cbm_pkg::RamEnableCode) begin
                state_next.ram_on = 1'b1;
              end else if (acc.value == cbm_pkg::RamDisableCode) begin
                state_next.ram_on = 1'b0;
              end
            end
            cbm_pkg::RangeRomBank: begin
              if (acc.address[12]) begin
                state_next.rom_page[8] = acc.value[0];
              end else begin
                state_next.rom_page[7:0] = acc.value;
              end
            end
            cbm_pkg::RangeRamBank: begin
              if (acc.value <= cbm_pkg::Mbc5MaxRamBank) begin
                state_next.ram_page = acc.value[3:0];
              end
            end
            default: begin
              state_next = state;
            end
          endcase
        end
      endcase
    end
  end

  // Hold kind and banking registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kind            <= cbm_pkg::KIND_NONE;
      state.rom_page  <= 9'd1;
      state.ram_page  <= '0;
      state.ram_on    <= 1'b0;
      state.bank_mode <= 1'b0;
    end else begin
      if (cfg_we) begin
        kind <= cbm_pkg::ctrl_kind_t'(cfg_wdata);
      end
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cbm_xlate.sv =====
// Address translation of one bus access through the current banks.
// Depends on cbm_pkg; purely combinational, feeds the result register.
`default_nettype none

module cbm_xlate #(
  parameter int RamBankBytes = cbm_pkg::RamBankBytes,
  parameter int RomBankBytes = cbm_pkg::RomBankBytes
) (
  input  wire cbm_pkg::access_t     acc,
  input  wire cbm_pkg::ctrl_kind_t  kind,
  input  wire cbm_pkg::bank_state_t state,
  output cbm_pkg::result_t          res
);

  localparam int RomOffsetBits = $clog2(RomBankBytes);

  logic                          in_ram_window;
  logic [cbm_pkg::PhysWidth-1:0] rom_addr;
  logic [cbm_pkg::PhysWidth-1:0] ram_addr;

  assign in_ram_window = (acc.address[15:13] == cbm_pkg::RamWindowBase[15:13]);

  // Switchable ROM window: bank times bank size plus offset in window
  assign rom_addr = cbm_pkg::PhysWidth'(state.rom_page) *
                    cbm_pkg::PhysWidth'(RomBankBytes) +
                    cbm_pkg::PhysWidth'(acc.address[RomOffsetBits-1:0]);

  // RAM window: bank times bank size plus offset from window base
  assign ram_addr = cbm_pkg::PhysWidth'(state.ram_page) *
                    cbm_pkg::PhysWidth'(RamBankBytes) +
                    cbm_pkg::PhysWidth'(acc.address - cbm_pkg::RamWindowBase);

  // Pick access kind and address
  always_comb begin
    res = '0;
    res.kind = cbm_pkg::ACC_NONE;
    if (!acc.command) begin
      if (!acc.address[15]) begin
        res.kind = cbm_pkg::ACC_ROM_READ;
        res.phys_address = acc.address[14] ? rom_addr
                                           : cbm_pkg::PhysWidth'(acc.address);
      end else if (in_ram_window && state.ram_on) begin
        res.kind         = cbm_pkg::ACC_RAM_READ;
        res.phys_address = ram_addr;
      end
    end else if (kind != cbm_pkg::KIND_NONE && in_ram_window && state.ram_on) begin
      res.kind         = cbm_pkg::ACC_RAM_WRITE;
      res.phys_address = ram_addr;
      res.write_data   = acc.value;
    end
  end

endmodule

`default_nettype wire
